// ----- src/rrp_pkg.sv -----
// Package for the ranging result post-processor.
// Holds payload types, status codes, register indexes and shared constants.
// No dependencies.
package rrp_pkg;

    localparam int DEPTH = 4;
    localparam int PTR_W = 2;
    localparam int CNT_W = 3;
    localparam int DIV_W = 32;

    localparam logic [15:0] TARGET_RESET = 16'd2560;
    localparam logic [11:0] GAIN_RESET   = 12'd2011;
    localparam logic [28:0] GAIN_ROUND   = 29'h0400;
    localparam int          GAIN_SHIFT   = 11;
    localparam logic [15:0] MAX16        = 16'hFFFF;
    localparam logic [15:0] SPAD_MID     = 16'h8000;

    localparam logic [7:0] RAW_HW_A   = 8'd1;
    localparam logic [7:0] RAW_HW_B   = 8'd2;
    localparam logic [7:0] RAW_HW_C   = 8'd3;
    localparam logic [7:0] RAW_SIGNAL = 8'd4;
    localparam logic [7:0] RAW_BOUNDS = 8'd5;
    localparam logic [7:0] RAW_SIGMA  = 8'd6;
    localparam logic [7:0] RAW_WRAP   = 8'd7;
    localparam logic [7:0] RAW_CLIP   = 8'd8;
    localparam logic [7:0] RAW_DONE   = 8'd9;
    localparam logic [7:0] RAW_XTALK  = 8'd12;
    localparam logic [7:0] RAW_MINRNG = 8'd13;
    localparam logic [7:0] RAW_HW_D   = 8'd17;
    localparam logic [7:0] RAW_SYNC   = 8'd18;

    typedef enum logic [0:0] {
        REG_TARGET_RATE = 1'b0,
        REG_RANGE_GAIN  = 1'b1
    } cfg_reg_t;

    typedef enum logic [3:0] {
        CODE_VALID      = 4'd0,
        CODE_SIGMA      = 4'd1,
        CODE_SIGNAL     = 4'd2,
        CODE_MINCLIPPED = 4'd3,
        CODE_BOUNDS     = 4'd4,
        CODE_HARDWARE   = 4'd5,
        CODE_NOWRAP     = 4'd6,
        CODE_WRAP       = 4'd7,
        CODE_XTALK      = 4'd8,
        CODE_SYNC       = 4'd9,
        CODE_MINRANGE   = 4'd10,
        CODE_NONE       = 4'd11
    } range_code_t;

    typedef struct packed {
        logic [7:0]  raw_status;
        logic [7:0]  stream_cnt;
        logic [15:0] effective_spads;
        logic [15:0] peak_rate;
        logic [15:0] ambient_rate;
        logic [15:0] raw_range;
    } in_t;

    typedef struct packed {
        logic [15:0] corr_range;
        range_code_t range_code;
        logic [15:0] requested_spads;
        logic [15:0] peak_rate_out;
        logic [15:0] ambient_rate_out;
    } out_t;

    typedef struct packed {
        logic [15:0] corr_range;
        range_code_t range_code;
        logic [15:0] spads;
        logic [15:0] total;
        logic [15:0] peak;
        logic [15:0] amb;
    } work_t;

    typedef struct packed {
        logic [15:0] corr_range;
        range_code_t range_code;
        logic [15:0] peak;
        logic [15:0] amb;
        logic        mid;
    } side_t;

endpackage

// ----- src/rrp_front.sv -----
// Front end: gain-corrects the range, maps the status code, sums the rates.
// Depends on rrp_pkg.
module rrp_front
    import rrp_pkg::*;
(
    input  in_t         in_data,
    input  logic [11:0] range_gain,
    output work_t       work
);

    logic [27:0] prod;
    logic [28:0] rounded;
    logic [17:0] scaled;
    logic [16:0] sum;
    range_code_t code;

    assign prod    = 28'(in_data.raw_range) * 28'(range_gain);
    assign rounded = {1'b0, prod} + GAIN_ROUND;
    assign scaled  = rounded[28:GAIN_SHIFT];
    assign sum     = {1'b0, in_data.peak_rate} + {1'b0, in_data.ambient_rate};

    always_comb
    begin
        unique case (in_data.raw_status) inside
            RAW_HW_A, RAW_HW_B, RAW_HW_C, RAW_HW_D: code = CODE_HARDWARE;
            RAW_SIGNAL: code = CODE_SIGNAL;
            RAW_BOUNDS: code = CODE_BOUNDS;
            RAW_SIGMA:  code = CODE_SIGMA;
            RAW_WRAP:   code = CODE_WRAP;
            RAW_CLIP:   code = CODE_MINCLIPPED;
            RAW_DONE:   code = (in_data.stream_cnt == 8'd0) ? CODE_NOWRAP : CODE_VALID;
            RAW_XTALK:  code = CODE_XTALK;
            RAW_MINRNG: code = CODE_MINRANGE;
            RAW_SYNC:   code = CODE_SYNC;
            default:    code = CODE_NONE;
        endcase
    end

    always_comb
    begin
        work.corr_range = (scaled[17:16] != 2'b00) ? MAX16 : scaled[15:0];
        work.range_code = code;
        work.spads      = in_data.effective_spads;
        work.total      = sum[16] ? MAX16 : sum[15:0];
        work.peak       = in_data.peak_rate;
        work.amb        = in_data.ambient_rate;
    end

endmodule

// ----- src/rrp_queue.sv -----
// Short queue between front and back ends.
// Depends on rrp_pkg.
module rrp_queue
    import rrp_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  work_t push_data,
    output logic  full,
    input  logic  pop,
    output logic  pop_valid,
    output work_t pop_data
);

    work_t            mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign pop_valid = (count_reg != '0);
    assign do_push   = push && !full;
    assign do_pop    = pop && pop_valid;
    assign pop_data  = mem_reg[rd_ptr_reg];

    assign wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
    assign rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
    assign count_next  = count_reg + CNT_W'(do_push) - CNT_W'(do_pop);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue count beyond depth");

    a_ptr_count: assert property (@(posedge clk) disable iff (!rst_n)
        (PTR_W'(wr_ptr_reg - rd_ptr_reg) == count_reg[PTR_W-1:0]))
        else $error("queue pointers disagree with count");

    a_push_only: assert property (@(posedge clk) disable iff (!rst_n)
        (do_push && !do_pop) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("queue count not advanced on push");

endmodule

// ----- src/rrp_div.sv -----
// Pipelined restoring divider, one quotient bit per stage, with sideband.
// Depends on rrp_pkg.
module rrp_div
    import rrp_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  logic             in_valid,
    input  logic [DIV_W-1:0] dividend,
    input  logic [DIV_W-1:0] divisor,
    input  side_t            side_in,
    output logic             out_valid,
    output logic [DIV_W-1:0] quotient,
    output side_t            side_out
);

    logic             v_reg    [DIV_W];
    logic [DIV_W-1:0] rem_reg  [DIV_W];
    logic [DIV_W-1:0] dvd_reg  [DIV_W];
    logic [DIV_W-1:0] dvs_reg  [DIV_W];
    logic [DIV_W-1:0] quo_reg  [DIV_W];
    side_t            side_reg [DIV_W];

    logic             v_next    [DIV_W];
    logic [DIV_W-1:0] rem_next  [DIV_W];
    logic [DIV_W-1:0] dvd_next  [DIV_W];
    logic [DIV_W-1:0] dvs_next  [DIV_W];
    logic [DIV_W-1:0] quo_next  [DIV_W];
    side_t            side_next [DIV_W];

    for (genvar k = 0; k < DIV_W; k++)
    begin : g_stage
        logic [DIV_W-1:0] src_rem, src_dvd, src_dvs, src_quo;
        logic [DIV_W:0]   shifted, diff;
        logic             ge;

        if (k == 0)
        begin : g_first
            assign v_next[k]    = in_valid;
            assign src_rem      = '0;
            assign src_dvd      = dividend;
            assign src_dvs      = divisor;
            assign src_quo      = '0;
            assign side_next[k] = side_in;
        end
        else
        begin : g_rest
            assign v_next[k]    = v_reg[k-1];
            assign src_rem      = rem_reg[k-1];
            assign src_dvd      = dvd_reg[k-1];
            assign src_dvs      = dvs_reg[k-1];
            assign src_quo      = quo_reg[k-1];
            assign side_next[k] = side_reg[k-1];
        end

        assign shifted     = {src_rem, src_dvd[DIV_W-1-k]};
        assign diff        = shifted - {1'b0, src_dvs};
        assign ge          = (shifted >= {1'b0, src_dvs});
        assign rem_next[k] = ge ? diff[DIV_W-1:0] : shifted[DIV_W-1:0];
        assign dvd_next[k] = src_dvd;
        assign dvs_next[k] = src_dvs;
        assign quo_next[k] = src_quo | (ge ? (DIV_W'(1) << (DIV_W-1-k)) : '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < DIV_W; k++)
            begin
                v_reg[k] <= 1'b0;
            end
        end
        else if (en)
        begin
            for (int k = 0; k < DIV_W; k++)
            begin
                v_reg[k] <= v_next[k];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < DIV_W; k++)
            begin
                rem_reg[k]  <= rem_next[k];
                dvd_reg[k]  <= dvd_next[k];
                dvs_reg[k]  <= dvs_next[k];
                quo_reg[k]  <= quo_next[k];
                side_reg[k] <= side_next[k];
            end
        end
    end

    assign out_valid = v_reg[DIV_W-1];
    assign quotient  = quo_reg[DIV_W-1];
    assign side_out  = side_reg[DIV_W-1];

endmodule

// ----- src/rrp_back.sv -----
// Back end: rate per SPAD and SPAD request through two pipelined dividers.
// Depends on rrp_pkg and rrp_div.
module rrp_back
    import rrp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic [15:0] target_rate,
    input  logic        work_valid,
    input  work_t       work,
    output logic        work_ready,
    output logic        out_valid,
    input  logic        out_ready,
    output out_t        out_data
);

    logic             en;
    side_t            side1_in, side1_out, side2_in, side2_out;
    logic             v1, v2;
    logic [DIV_W-1:0] q1, q2;
    logic [15:0]      req;

    assign en         = !v2 || out_ready;
    assign work_ready = en;

    always_comb
    begin
        side1_in.corr_range = work.corr_range;
        side1_in.range_code = work.range_code;
        side1_in.peak       = work.peak;
        side1_in.amb        = work.amb;
        side1_in.mid        = (work.spads == 16'd0);
    end

    rrp_div u_div_rate (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (work_valid),
        .dividend ({work.total, 16'h0000}),
        .divisor  ({16'h0000, work.spads}),
        .side_in  (side1_in),
        .out_valid(v1),
        .quotient (q1),
        .side_out (side1_out)
    );

    always_comb
    begin
        side2_in     = side1_out;
        side2_in.mid = side1_out.mid || (q1 == '0);
    end

    rrp_div u_div_req (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (v1),
        .dividend ({target_rate, 16'h0000}),
        .divisor  (q1),
        .side_in  (side2_in),
        .out_valid(v2),
        .quotient (q2),
        .side_out (side2_out)
    );

    assign req = (q2[DIV_W-1:16] != '0) ? MAX16 : q2[15:0];

    always_comb
    begin
        out_data.corr_range       = side2_out.corr_range;
        out_data.range_code       = side2_out.range_code;
        out_data.requested_spads  = side2_out.mid ? SPAD_MID : req;
        out_data.peak_rate_out    = side2_out.peak;
        out_data.ambient_rate_out = side2_out.amb;
    end

    assign out_valid = v2;

endmodule

// ----- src/ranging_result_postprocess.sv -----
// Top level of the ranging result post-processor.
// Depends on rrp_pkg, rrp_front, rrp_queue and rrp_back.

// One result beat per record, one record per cycle sustained while out_ready
// is high. A record is classified on acceptance (gain multiply, status map,
// rate sum) and held in a four-beat queue; the back end runs two 32-stage
// pipelined dividers, so a record passes the queue entry, then the rate
// divider stages, then the request divider stages; a finished result held
// by a low out_ready stalls both dividers while the record is in flight.
module ranging_result_postprocess
    import rrp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  in_t         in_data,
    output logic        out_valid,
    input  logic        out_ready,
    output out_t        out_data,
    input  logic        cfg_we,
    input  logic [0:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    logic [15:0] target_rate_reg;
    logic [11:0] range_gain_reg;
    work_t       front_work, queue_work;
    logic        full, queue_valid, back_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_rate_reg <= TARGET_RESET;
            range_gain_reg  <= GAIN_RESET;
        end
        else if (cfg_we)
        begin
            if (cfg_index == REG_TARGET_RATE)
            begin
                target_rate_reg <= cfg_data;
            end
            else if (cfg_index == REG_RANGE_GAIN)
            begin
                range_gain_reg <= cfg_data[11:0];
            end
        end
    end

    rrp_front u_front (
        .in_data   (in_data),
        .range_gain(range_gain_reg),
        .work      (front_work)
    );

    assign in_ready = !full;

    rrp_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (in_valid),
        .push_data(front_work),
        .full     (full),
        .pop      (back_ready),
        .pop_valid(queue_valid),
        .pop_data (queue_work)
    );

    rrp_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .target_rate(target_rate_reg),
        .work_valid (queue_valid),
        .work       (queue_work),
        .work_ready (back_ready),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_data   (out_data)
    );

endmodule
